>>> design/software_timer_table_assert.svh
// ----------------------------------------------------------------------------
// Software timer table assertion macros
// Shared helpers for the concurrent checks in the timer table design.
// ----------------------------------------------------------------------------
`ifndef SOFTWARE_TIMER_TABLE_ASSERT_SVH
`define SOFTWARE_TIMER_TABLE_ASSERT_SVH

// A condition that holds at every clock edge outside reset.
`define STT_ASSERT_ALWAYS(lbl, clk, rst, cond) \
   lbl: assert property (@(posedge clk) disable iff (rst) (cond)) \
      else $error("Timer table invariant violated.");

// An implication checked at every clock edge outside reset.
`define STT_ASSERT_IMPL(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("Timer table implication violated.");

`endif

>>> design/stt_pkg.sv
// ----------------------------------------------------------------------------
// Software timer table package
// Command codes, status codes and the types shared between the modules.
// ----------------------------------------------------------------------------
`default_nettype none
package stt_pkg;

   localparam logic [1:0] CMD_TICK   = 2'd0;
   localparam logic [1:0] CMD_START  = 2'd1;
   localparam logic [1:0] CMD_STOP   = 2'd2;
   localparam logic [1:0] CMD_UNUSED = 2'd3;

   localparam logic [1:0] STATUS_OK   = 2'd0;
   localparam logic [1:0] STATUS_FULL = 2'd1;
   localparam logic [1:0] STATUS_ZERO = 2'd2;

   localparam logic KIND_STATUS = 1'b0;
   localparam logic KIND_FIRED  = 1'b1;

   localparam int ENTRY_WIDTH = 25;

   typedef struct packed {
      logic [1:0]  cmd;
      logic [7:0]  handle;
      logic [15:0] delay_us;
      logic        periodic;
   } request_type;

   typedef struct packed {
      logic [15:0] delay;
      logic [7:0]  handle;
      logic        periodic;
   } entry_type;

endpackage
`default_nettype wire

>>> design/stt_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// Single write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none
module stt_ram #(
   parameter int WIDTH = 25,
   parameter int DEPTH = 16,
   parameter int AW    = 4
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule
`default_nettype wire

>>> design/stt_divider.sv
// ----------------------------------------------------------------------------
// Software timer table divider
// Restoring divider producing one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none
module stt_divider (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   input  wire logic [15:0] dividend,
   input  wire logic [15:0] divisor,
   input  wire logic [4:0]  steps,
   output logic             done,
   output logic      [15:0] quotient,
   output logic      [15:0] remainder
);

   logic [15:0] dq_ff, dq_in;
   logic [16:0] rem_ff, rem_in;
   logic [15:0] div_ff, div_in;
   logic [4:0]  cnt_ff, cnt_in;
   logic        done_ff, done_in;
   logic [16:0] trial;
   logic        ge;

   always_comb begin
      trial  = {rem_ff[15:0], dq_ff[15]};
      ge     = trial >= {1'b0, div_ff};
      dq_in  = dq_ff;
      rem_in = rem_ff;
      div_in = div_ff;
      cnt_in = cnt_ff;
      done_in = 1'b0;
      if (start) begin
         dq_in  = dividend;
         rem_in = '0;
         div_in = divisor;
         cnt_in = steps;
      end else if (cnt_ff != 5'd0) begin
         dq_in  = {dq_ff[14:0], ge};
         rem_in = ge ? (trial - {1'b0, div_ff}) : trial;
         cnt_in = cnt_ff - 5'd1;
         done_in = (cnt_ff == 5'd1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         done_ff <= done_in;
      end
      dq_ff  <= dq_in;
      rem_ff <= rem_in;
      div_ff <= div_in;
   end

   assign done      = done_ff;
   assign quotient  = dq_ff;
   assign remainder = rem_ff[15:0];

endmodule
`default_nettype wire

>>> design/stt_front.sv
// ----------------------------------------------------------------------------
// Software timer table front end
// Accepts requests and holds them in a two-entry queue for the back end.
// ----------------------------------------------------------------------------
`default_nettype none
module stt_front (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 start,
   input  wire stt_pkg::request_type req,
   output logic                      busy,
   output logic                      q_valid,
   output stt_pkg::request_type      q_head,
   input  wire logic                 q_pop
);

   stt_pkg::request_type slot_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] cnt_ff, cnt_in;
   logic       push;
   logic       pop;

   always_comb begin
      push      = start && !busy && (req.cmd != stt_pkg::CMD_UNUSED);
      pop       = q_pop && q_valid;
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? !rd_ptr_ff : rd_ptr_ff;
      cnt_in    = cnt_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
      if (push) begin
         slot_ff[wr_ptr_ff] <= req;
      end
   end

   assign busy    = (cnt_ff == 2'd2);
   assign q_valid = (cnt_ff != 2'd0);
   assign q_head  = slot_ff[rd_ptr_ff];

endmodule
`default_nettype wire

>>> design/stt_back.sv
// ----------------------------------------------------------------------------
// Software timer table back end
// Executes ticks, starts and stops against the entry store.
// ----------------------------------------------------------------------------
`default_nettype none
module stt_back #(
   parameter int TIMER_SLOTS = 16
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 q_valid,
   input  wire stt_pkg::request_type q_head,
   output logic                      q_pop,
   input  wire logic [7:0]           match_count,
   input  wire logic [15:0]          resolution_us,
   output logic                      rsp_strobe,
   output logic                      rsp_kind,
   output logic [7:0]                rsp_fired_handle,
   output logic [1:0]                rsp_status,
   output logic                      rsp_last
);

   `include "software_timer_table_assert.svh"

   localparam int AW = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1;
   localparam int CW = $clog2(TIMER_SLOTS + 1);
   localparam logic [CW-1:0] SLOTS = CW'(TIMER_SLOTS);

   typedef enum logic [7:0] {
      S_IDLE = 8'b0000_0001,
      S_RD   = 8'b0000_0010,
      S_WAIT = 8'b0000_0100,
      S_MOD  = 8'b0000_1000,
      S_MVRD = 8'b0001_0000,
      S_MVWR = 8'b0010_0000,
      S_DIV  = 8'b0100_0000,
      S_DONE = 8'b1000_0000
   } state_type;

   state_type state_ff, state_in;
   stt_pkg::request_type cur_ff, cur_in;
   stt_pkg::entry_type   ent_ff, ent_in;
   logic [7:0]    prescale_ff, prescale_in;
   logic [7:0]    tick_ff, tick_in;
   logic [CW-1:0] count_ff, count_in;
   logic [CW-1:0] idx_ff, idx_in;
   logic          pend_ff, pend_in;
   logic [7:0]    pend_handle_ff, pend_handle_in;
   logic          strobe_ff, strobe_in;
   logic          kind_ff, kind_in;
   logic [7:0]    handle_ff, handle_in;
   logic [1:0]    status_ff, status_in;
   logic          last_ff, last_in;

   logic          ram_we;
   logic [AW-1:0] ram_waddr, ram_raddr;
   logic [stt_pkg::ENTRY_WIDTH-1:0] ram_wdata, ram_rdata;
   stt_pkg::entry_type rd_entry;

   logic        div_start, div_done;
   logic [15:0] div_dividend, div_divisor, div_q, div_r;
   logic [4:0]  div_steps;
   logic [7:0]  match_eff;

   stt_ram #(.WIDTH(stt_pkg::ENTRY_WIDTH), .DEPTH(TIMER_SLOTS), .AW(AW)) u_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   stt_divider u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (div_dividend),
      .divisor   (div_divisor),
      .steps     (div_steps),
      .done      (div_done),
      .quotient  (div_q),
      .remainder (div_r)
   );

   assign rd_entry  = stt_pkg::entry_type'(ram_rdata);
   assign match_eff = (match_count == 8'd0) ? 8'd1 : match_count;

   always_comb begin
      state_in       = state_ff;
      cur_in         = cur_ff;
      ent_in         = ent_ff;
      prescale_in    = prescale_ff;
      tick_in        = tick_ff;
      count_in       = count_ff;
      idx_in         = idx_ff;
      pend_in        = pend_ff;
      pend_handle_in = pend_handle_ff;
      strobe_in      = 1'b0;
      kind_in        = kind_ff;
      handle_in      = handle_ff;
      status_in      = status_ff;
      last_in        = last_ff;
      q_pop          = 1'b0;
      ram_we         = 1'b0;
      ram_waddr      = idx_ff[AW-1:0];
      ram_wdata      = ram_rdata;
      ram_raddr      = idx_ff[AW-1:0];
      div_start      = 1'b0;
      div_dividend   = q_head.delay_us;
      div_divisor    = (resolution_us == 16'd0) ? 16'd1 : resolution_us;
      div_steps      = 5'd16;
      case (state_ff)
         S_IDLE: begin
            if (q_valid) begin
               q_pop  = 1'b1;
               cur_in = q_head;
               idx_in = '0;
               case (q_head.cmd)
                  stt_pkg::CMD_TICK: begin
                     if (prescale_ff + 8'd1 >= match_eff) begin
                        prescale_in = 8'd0;
                        tick_in     = tick_ff + 8'd1;
                        state_in    = S_RD;
                     end else begin
                        prescale_in = prescale_ff + 8'd1;
                     end
                  end
                  stt_pkg::CMD_START: begin
                     if (count_ff >= SLOTS) begin
                        strobe_in = 1'b1;
                        kind_in   = stt_pkg::KIND_STATUS;
                        handle_in = q_head.handle;
                        status_in = stt_pkg::STATUS_FULL;
                        last_in   = 1'b1;
                     end else begin
                        div_start = 1'b1;
                        state_in  = S_DIV;
                     end
                  end
                  stt_pkg::CMD_STOP: begin
                     state_in = S_RD;
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_RD: begin
            if (idx_ff >= count_ff) begin
               state_in = S_DONE;
            end else begin
               state_in = S_WAIT;
            end
         end
         S_WAIT: begin
            ent_in = rd_entry;
            if (cur_ff.cmd == stt_pkg::CMD_STOP) begin
               if (rd_entry.handle == cur_ff.handle) begin
                  state_in = S_MVRD;
               end else begin
                  idx_in   = idx_ff + CW'(1);
                  state_in = S_RD;
               end
            end else begin
               div_start    = 1'b1;
               div_dividend = {tick_ff, 8'h00};
               div_divisor  = (rd_entry.delay == 16'd0) ? 16'd1 : rd_entry.delay;
               div_steps    = 5'd8;
               state_in     = S_MOD;
            end
         end
         S_MOD: begin
            if (div_done) begin
               if (div_r == 16'd0) begin
                  if (pend_ff) begin
                     strobe_in = 1'b1;
                     kind_in   = stt_pkg::KIND_FIRED;
                     handle_in = pend_handle_ff;
                     status_in = stt_pkg::STATUS_OK;
                     last_in   = 1'b0;
                  end
                  pend_in        = 1'b1;
                  pend_handle_in = ent_ff.handle;
                  if (ent_ff.periodic) begin
                     idx_in   = idx_ff + CW'(1);
                     state_in = S_RD;
                  end else begin
                     state_in = S_MVRD;
                  end
               end else begin
                  idx_in   = idx_ff + CW'(1);
                  state_in = S_RD;
               end
            end
         end
         S_MVRD: begin
            ram_raddr = AW'(count_ff - CW'(1));
            state_in  = S_MVWR;
         end
         S_MVWR: begin
            ram_we   = 1'b1;
            count_in = count_ff - CW'(1);
            state_in = S_RD;
         end
         S_DIV: begin
            if (div_done) begin
               strobe_in = 1'b1;
               kind_in   = stt_pkg::KIND_STATUS;
               handle_in = cur_ff.handle;
               last_in   = 1'b1;
               if (div_q == 16'd0) begin
                  status_in = stt_pkg::STATUS_ZERO;
               end else begin
                  status_in = stt_pkg::STATUS_OK;
                  ram_we    = 1'b1;
                  ram_waddr = count_ff[AW-1:0];
                  ram_wdata = {div_q, cur_ff.handle, cur_ff.periodic};
                  count_in  = count_ff + CW'(1);
               end
               state_in = S_IDLE;
            end
         end
         S_DONE: begin
            if (cur_ff.cmd == stt_pkg::CMD_STOP) begin
               strobe_in = 1'b1;
               kind_in   = stt_pkg::KIND_STATUS;
               handle_in = cur_ff.handle;
               status_in = stt_pkg::STATUS_OK;
               last_in   = 1'b1;
            end else if (pend_ff) begin
               strobe_in = 1'b1;
               kind_in   = stt_pkg::KIND_FIRED;
               handle_in = pend_handle_ff;
               status_in = stt_pkg::STATUS_OK;
               last_in   = 1'b1;
            end
            pend_in  = 1'b0;
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= S_IDLE;
         prescale_ff <= '0;
         tick_ff     <= '0;
         count_ff    <= '0;
         pend_ff     <= 1'b0;
         strobe_ff   <= 1'b0;
      end else begin
         state_ff    <= state_in;
         prescale_ff <= prescale_in;
         tick_ff     <= tick_in;
         count_ff    <= count_in;
         pend_ff     <= pend_in;
         strobe_ff   <= strobe_in;
      end
      cur_ff         <= cur_in;
      ent_ff         <= ent_in;
      idx_ff         <= idx_in;
      pend_handle_ff <= pend_handle_in;
      kind_ff        <= kind_in;
      handle_ff      <= handle_in;
      status_ff      <= status_in;
      last_ff        <= last_in;
   end

   assign rsp_strobe       = strobe_ff;
   assign rsp_kind         = kind_ff;
   assign rsp_fired_handle = handle_ff;
   assign rsp_status       = status_ff;
   assign rsp_last         = last_ff;

   `STT_ASSERT_ALWAYS(a_count_bound, clock, reset, count_ff <= SLOTS)
   `STT_ASSERT_IMPL(a_status_last, clock, reset,
      strobe_ff && kind_ff == stt_pkg::KIND_STATUS, last_ff)
   `STT_ASSERT_IMPL(a_fired_ok, clock, reset,
      strobe_ff && kind_ff == stt_pkg::KIND_FIRED, status_ff == stt_pkg::STATUS_OK)
   `STT_ASSERT_IMPL(a_pend_clear, clock, reset, state_ff == S_IDLE, !pend_ff)

endmodule
`default_nettype wire

>>> design/software_timer_table.sv
// ----------------------------------------------------------------------------
// Software timer table
// Timer table advanced by hardware ticks, with start and stop requests.
// ----------------------------------------------------------------------------
// Start runs the 16-step divider; stop reads each entry in S_RD and S_WAIT
// and moves the last entry into each removed slot in S_MVRD and S_MVWR. A
// system tick scans each entry with the 8-step modulo in the shared divider.
// Up to two requests are queued; busy is high while the queue is full.
// Reset clears the counters and the queue; the entry store is not cleared.
`default_nettype none
module software_timer_table #(
   parameter int TIMER_SLOTS = 16
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   output logic             busy,
   input  wire logic [1:0]  req_cmd,
   input  wire logic [7:0]  req_handle,
   input  wire logic [15:0] req_delay_us,
   input  wire logic        req_periodic,
   output logic             rsp_strobe,
   output logic             rsp_kind,
   output logic [7:0]       rsp_fired_handle,
   output logic [1:0]       rsp_status,
   output logic             rsp_last,
   input  wire logic        psel,
   input  wire logic        penable,
   input  wire logic        pwrite,
   input  wire logic [2:0]  paddr,
   input  wire logic [31:0] pwdata,
   output logic      [31:0] prdata,
   output logic             pready
);

   stt_pkg::request_type req, q_head;
   logic        q_valid, q_pop;
   logic [7:0]  match_ff;
   logic [15:0] resolution_ff;
   logic        wr;

   assign req = '{cmd: req_cmd, handle: req_handle, delay_us: req_delay_us,
                  periodic: req_periodic};

   assign pready = 1'b1;
   assign wr     = psel && penable && pwrite;
   assign prdata = paddr[2] ? {16'd0, resolution_ff} : {24'd0, match_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         match_ff      <= 8'd1;
         resolution_ff <= 16'd1;
      end else if (wr) begin
         if (paddr[2]) begin
            resolution_ff <= pwdata[15:0];
         end else begin
            match_ff <= pwdata[7:0];
         end
      end
   end

   stt_front u_front (
      .clock   (clock),
      .reset   (reset),
      .start   (start),
      .req     (req),
      .busy    (busy),
      .q_valid (q_valid),
      .q_head  (q_head),
      .q_pop   (q_pop)
   );

   stt_back #(.TIMER_SLOTS(TIMER_SLOTS)) u_back (
      .clock            (clock),
      .reset            (reset),
      .q_valid          (q_valid),
      .q_head           (q_head),
      .q_pop            (q_pop),
      .match_count      (match_ff),
      .resolution_us    (resolution_ff),
      .rsp_strobe       (rsp_strobe),
      .rsp_kind         (rsp_kind),
      .rsp_fired_handle (rsp_fired_handle),
      .rsp_status       (rsp_status),
      .rsp_last         (rsp_last)
   );

endmodule
`default_nettype wire

>>> verif/software_timer_table_checker.sv
// ----------------------------------------------------------------------------
// Software timer table checker
// Watches the request, result and register ports, predicts the results of
// every accepted request and compares them in order with those observed.
// ----------------------------------------------------------------------------
`default_nettype none
module software_timer_table_checker #(
   parameter int TIMER_SLOTS = 16
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   input  wire logic        busy,
   input  wire logic [1:0]  req_cmd,
   input  wire logic [7:0]  req_handle,
   input  wire logic [15:0] req_delay_us,
   input  wire logic        req_periodic,
   input  wire logic        rsp_strobe,
   input  wire logic        rsp_kind,
   input  wire logic [7:0]  rsp_fired_handle,
   input  wire logic [1:0]  rsp_status,
   input  wire logic        rsp_last,
   input  wire logic        psel,
   input  wire logic        penable,
   input  wire logic        pwrite,
   input  wire logic        pready,
   input  wire logic [2:0]  paddr,
   input  wire logic [31:0] pwdata,
   output int               fail_count,
   output int               pending,
   output int               results_seen
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [2:0] ADDR_MATCH_COUNT = 3'd0;
   localparam logic [2:0] ADDR_RESOLUTION  = 3'd4;

   typedef struct packed {
      logic       kind;
      logic [7:0] handle;
      logic [1:0] status;
      logic       last;
   } timer_result_type;

   timer_result_type   expected_results[$];
   stt_pkg::entry_type timers[TIMER_SLOTS];
   logic [7:0]         ticks_per_system_tick;
   logic [15:0]        microseconds_per_tick;
   logic [7:0]         prescaler;
   logic [7:0]         system_tick;
   int                 timer_count;

   function automatic void push_result(logic kind, logic [7:0] handle,
                                       logic [1:0] status, logic last);
      timer_result_type r;
      r.kind = kind;
      r.handle = handle;
      r.status = status;
      r.last = last;
      expected_results.push_back(r);
   endfunction

   function automatic void remove_timer(int slot);
      timers[slot] = timers[timer_count - 1];
      timer_count--;
   endfunction

   function automatic void advance_tick();
      int          slot;
      int          fired;
      logic [15:0] period;
      slot = 0;
      fired = 0;
      prescaler = prescaler + 8'd1;
      if (prescaler < ticks_per_system_tick) return;
      prescaler = 8'd0;
      system_tick = system_tick + 8'd1;
      while (slot < timer_count) begin
         period = (timers[slot].delay == 16'd0) ? 16'd1 : timers[slot].delay;
         if ((16'(system_tick) % period) == 16'd0) begin
            push_result(stt_pkg::KIND_FIRED, timers[slot].handle,
                        stt_pkg::STATUS_OK, 1'b0);
            fired++;
            if (!timers[slot].periodic) begin
               remove_timer(slot);
               continue;
            end
         end
         slot++;
      end
      if (fired > 0) expected_results[$].last = 1'b1;
   endfunction

   function automatic void predict_request(logic [1:0] cmd, logic [7:0] handle,
                                           logic [15:0] delay_us, logic periodic);
      logic [15:0] divisor;
      logic [15:0] period;
      logic [1:0]  status;
      int          slot;
      case (cmd)
         stt_pkg::CMD_TICK: advance_tick();
         stt_pkg::CMD_START: begin
            divisor = (microseconds_per_tick == 16'd0) ? 16'd1 : microseconds_per_tick;
            period = delay_us / divisor;
            status = stt_pkg::STATUS_OK;
            if (timer_count >= TIMER_SLOTS) begin
               status = stt_pkg::STATUS_FULL;
            end else if (period == 16'd0) begin
               status = stt_pkg::STATUS_ZERO;
            end else begin
               timers[timer_count] = '{delay: period, handle: handle, periodic: periodic};
               timer_count++;
            end
            push_result(stt_pkg::KIND_STATUS, handle, status, 1'b1);
         end
         stt_pkg::CMD_STOP: begin
            slot = 0;
            while (slot < timer_count) begin
               if (timers[slot].handle == handle) remove_timer(slot);
               else slot++;
            end
            push_result(stt_pkg::KIND_STATUS, handle, stt_pkg::STATUS_OK, 1'b1);
         end
         default: ;
      endcase
   endfunction

   always @(posedge clock) begin
      timer_result_type seen;
      timer_result_type want;
      if (reset) begin
         ticks_per_system_tick = 8'd1;
         microseconds_per_tick = 16'd1;
         prescaler = 8'd0;
         system_tick = 8'd0;
         timer_count = 0;
         expected_results.delete();
      end else begin
         if (rsp_strobe) begin
            seen = '{kind: rsp_kind, handle: rsp_fired_handle,
                     status: rsp_status, last: rsp_last};
            results_seen++;
            if (expected_results.size() == 0) begin
               fail_count++;
               if (fail_count <= 10)
                  $display("%0t: unexpected result %p", $realtime, seen);
            end else begin
               want = expected_results.pop_front();
               if (seen !== want) begin
                  fail_count++;
                  if (fail_count <= 10)
                     $display("%0t: result mismatch, expected %p, got %p",
                              $realtime, want, seen);
               end
            end
         end
         if (psel && penable && pwrite && pready) begin
            if (paddr == ADDR_MATCH_COUNT) ticks_per_system_tick = pwdata[7:0];
            if (paddr == ADDR_RESOLUTION) microseconds_per_tick = pwdata[15:0];
         end
         if (start && !busy)
            predict_request(req_cmd, req_handle, req_delay_us, req_periodic);
      end
      pending = expected_results.size();
   end

   initial begin
      fail_count = 0;
      pending = 0;
      results_seen = 0;
   end

endmodule
`default_nettype wire

>>> verif/software_timer_table_tb.sv
// ----------------------------------------------------------------------------
// Software timer table testbench
// Drives tick, start and stop requests in random bursts under several
// register settings; the checker predicts and compares every result.
// ----------------------------------------------------------------------------
`default_nettype none
module software_timer_table_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [2:0] ADDR_MATCH_COUNT = 3'd0;
   localparam logic [2:0] ADDR_RESOLUTION  = 3'd4;
   localparam int         SETTLE_CYCLES    = 1000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   logic [1:0]  req_cmd = stt_pkg::CMD_TICK;
   logic [7:0]  req_handle = '0;
   logic [15:0] req_delay_us = '0;
   logic        req_periodic = 1'b0;
   logic        rsp_strobe;
   logic        rsp_kind;
   logic [7:0]  rsp_fired_handle;
   logic [1:0]  rsp_status;
   logic        rsp_last;
   logic        psel = 1'b0;
   logic        penable = 1'b0;
   logic        pwrite = 1'b0;
   logic [2:0]  paddr = '0;
   logic [31:0] pwdata = '0;
   logic [31:0] prdata;
   logic        pready;
   int          fail_count;
   int          pending;
   int          results_seen;
   int          requests_sent;
   logic [15:0] resolution;
   int          burst_left;

   software_timer_table dut (.*);

   software_timer_table_checker u_checker (
      .clock, .reset, .start, .busy, .req_cmd, .req_handle, .req_delay_us,
      .req_periodic, .rsp_strobe, .rsp_kind, .rsp_fired_handle, .rsp_status,
      .rsp_last, .psel, .penable, .pwrite, .pready, .paddr, .pwdata,
      .fail_count, .pending, .results_seen
   );

   initial begin
      forever #10 clock = ~clock;
   end

   initial begin
      #20ms;
      $display("Timeout with %0d results outstanding.", pending);
      $display("** software_timer_table: FAILED **");
      $finish;
   end

   task automatic send(logic [1:0] cmd, logic [7:0] handle, logic [15:0] delay_us,
                       logic periodic);
      start <= 1'b1;
      req_cmd <= cmd;
      req_handle <= handle;
      req_delay_us <= delay_us;
      req_periodic <= periodic;
      do @(posedge clock); while (busy);
      requests_sent++;
   endtask

   task automatic pause(int cycles);
      start <= 1'b0;
      repeat (cycles) @(posedge clock);
   endtask

   task automatic drain();
      pause(1);
      while (pending != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_register(logic [2:0] addr, logic [31:0] value);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= addr;
      pwdata <= value;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
   endtask

   task automatic configure(logic [7:0] match_count, logic [15:0] resolution_us);
      write_register(ADDR_MATCH_COUNT, {24'd0, match_count});
      write_register(ADDR_RESOLUTION, {16'd0, resolution_us});
      resolution = resolution_us;
   endtask

   task automatic random_request();
      logic [1:0]  cmd;
      logic [7:0]  handle;
      logic [15:0] delay_us;
      int          pick;
      int          span;
      pick = $urandom_range(0, 99);
      if (pick < 50) cmd = stt_pkg::CMD_TICK;
      else if (pick < 78) cmd = stt_pkg::CMD_START;
      else if (pick < 95) cmd = stt_pkg::CMD_STOP;
      else cmd = stt_pkg::CMD_UNUSED;
      handle = ($urandom_range(0, 7) == 0) ? 8'($urandom) : 8'($urandom_range(0, 7));
      span = ((resolution == 16'd0) ? 1 : int'(resolution)) * 6;
      if (span > 65535) span = 65535;
      delay_us = ($urandom_range(0, 4) == 0) ? 16'($urandom) : 16'($urandom_range(0, span));
      send(cmd, handle, delay_us, 1'($urandom));
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 20);
         if ($urandom_range(0, 2) != 0) pause($urandom_range(1, 12));
      end else begin
         burst_left--;
      end
   endtask

   initial begin
      logic [7:0]  match_settings[6];
      logic [15:0] resolution_settings[6];
      match_settings = '{8'd1, 8'd2, 8'd0, 8'd255, 8'd5, 8'd1};
      resolution_settings = '{16'd1, 16'd100, 16'd0, 16'd65535, 16'd3, 16'd1};
      requests_sent = 0;
      burst_left = 0;
      resolution = 16'd1;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send(stt_pkg::CMD_START, 8'd0, 16'd0, 1'b0);
      send(stt_pkg::CMD_START, 8'd10, 16'd1, 1'b0);
      send(stt_pkg::CMD_START, 8'd11, 16'd1, 1'b0);
      send(stt_pkg::CMD_START, 8'd2, 16'd2, 1'b1);
      send(stt_pkg::CMD_START, 8'd255, 16'd65535, 1'b1);
      send(stt_pkg::CMD_UNUSED, 8'hFF, 16'hFFFF, 1'b1);
      send(stt_pkg::CMD_TICK, 8'd0, 16'd0, 1'b0);
      send(stt_pkg::CMD_TICK, 8'd0, 16'd0, 1'b0);
      send(stt_pkg::CMD_STOP, 8'd200, 16'd0, 1'b0);
      send(stt_pkg::CMD_STOP, 8'd2, 16'd0, 1'b0);
      for (int i = 0; i < 16; i++) send(stt_pkg::CMD_START, 8'(i), 16'(i % 3 + 1), 1'(i));
      send(stt_pkg::CMD_START, 8'd77, 16'd5, 1'b0);
      send(stt_pkg::CMD_TICK, 8'd0, 16'd0, 1'b0);
      send(stt_pkg::CMD_STOP, 8'd255, 16'd0, 1'b0);

      for (int phase = 0; phase < 6; phase++) begin
         drain();
         configure(match_settings[phase], resolution_settings[phase]);
         if (phase == 3) send(stt_pkg::CMD_START, 8'd5, 16'hFFFF, 1'b1);
         for (int n = 0; n < 65; n++) random_request();
      end

      drain();
      $display("Sent %0d requests over six register settings, %0d results checked.",
               requests_sent, results_seen);
      if (fail_count == 0 && pending == 0) begin
         $display("** software_timer_table: PASSED **");
      end else begin
         $display("** software_timer_table: FAILED **");
      end
      $finish;
   end

endmodule
`default_nettype wire
